// ===== rtl/hpt_pkg.sv =====
// Shared types and constants of the homogeneous point transform.
package hpt_pkg;

    localparam int DATA_W  = 32;           // matrix element and coordinate width
    localparam int OP_W    = 2;
    localparam int IDX_W   = 4;            // row * 4 + column
    localparam int ROW_W   = 2;
    localparam int COL_W   = 3;            // counts 0..4 through one row
    localparam int PROD_W  = 2 * DATA_W;   // exact element * coordinate
    localparam int SUM_W   = PROD_W + 2;   // exact sum of four products
    localparam int MAG_W   = SUM_W - 1;    // magnitude of a row sum
    localparam int QUOT_W  = 32;           // saturated quotient width
    localparam int STEP_W  = 6;            // quotient step counter, QUOT_W..0

    localparam int IN_DATA_W  = 136;       // 132 bits of fields padded to bytes
    localparam int OUT_DATA_W = 96;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 2'd0,
        OP_TRANSLATE = 2'd1,
        OP_TRANSFORM = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRANS,
        S_MAC,
        S_START,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// ===== rtl/hpt_div.sv =====
// Iterative signed divider: (num << FRAC_BITS) / den, truncated, saturated to 32 bits.
module hpt_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [hpt_pkg::SUM_W-1:0]       i_num,
    input  logic signed [hpt_pkg::SUM_W-1:0]       i_den,
    output logic                                   o_done,
    output logic        [hpt_pkg::QUOT_W-1:0]      o_quot
);

    localparam int SHW   = (FRAC_BITS > hpt_pkg::QUOT_W) ? FRAC_BITS : hpt_pkg::QUOT_W;
    localparam int DIV_W = hpt_pkg::MAG_W + SHW;

    logic                            num_neg;
    logic                            den_neg;
    logic [hpt_pkg::SUM_W-1:0]       num_abs;
    logic [hpt_pkg::SUM_W-1:0]       den_abs;
    logic                            ge;
    logic [DIV_W-1:0]                diff;
    logic [hpt_pkg::QUOT_W-1:0]      limit;
    logic [hpt_pkg::QUOT_W-1:0]      mag;

    logic                            r_busy;
    logic                            r_fin;
    logic                            r_done;
    logic [hpt_pkg::STEP_W-1:0]      r_step;
    logic [DIV_W-1:0]                r_rem;
    logic [DIV_W-1:0]                r_dsh;
    logic [hpt_pkg::QUOT_W-1:0]      r_q;
    logic                            r_ovf;
    logic                            r_neg;
    logic [hpt_pkg::QUOT_W-1:0]      r_quot;

    assign num_neg = i_num[hpt_pkg::SUM_W-1];
    assign den_neg = i_den[hpt_pkg::SUM_W-1];
    assign num_abs = num_neg ? (~i_num + 1'b1) : i_num;
    assign den_abs = den_neg ? (~i_den + 1'b1) : i_den;

    assign ge   = (r_rem >= r_dsh);
    assign diff = r_rem - r_dsh;

    assign limit = r_neg ? hpt_pkg::SAT_MIN : hpt_pkg::SAT_MAX;
    assign mag   = (r_ovf || (r_q > limit)) ? limit : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= DIV_W'(num_abs[hpt_pkg::MAG_W-1:0]) << FRAC_BITS;
            r_dsh  <= DIV_W'(den_abs[hpt_pkg::MAG_W-1:0]) << hpt_pkg::QUOT_W;
            r_step <= hpt_pkg::STEP_W'(hpt_pkg::QUOT_W);
            r_q    <= '0;
            r_ovf  <= 1'b0;
            r_neg  <= num_neg ^ den_neg;
        end else if (r_busy) begin
            // top step only detects a quotient of 2^32 or more
            if (ge) begin
                r_rem <= diff;
            end
            if (r_step == hpt_pkg::STEP_W'(hpt_pkg::QUOT_W)) begin
                r_ovf <= ge;
            end else begin
                r_q <= {r_q[hpt_pkg::QUOT_W-2:0], ge};
            end
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step - 1'b1;
        end
        if (r_fin) begin
            r_quot <= r_neg ? (~mag + 1'b1) : mag;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/homogeneous_point_transform.sv =====
// Top level of the homogeneous 4x4 point transform with perspective divide.
//
//  channel  | direction | tdata (low bit up)                         | tuser
//  ---------+-----------+--------------------------------------------+--------------
//  s (in)   | request   | elem_index, elem_value, coord_x/y/z, pad   | op
//  m (out)  | result    | out_x, out_y, out_z                        | zero_divisor
//
// Steps: a write goes straight into the matrix, a translate makes three saturating adds, a transform
// runs a multiply-accumulate pass over each row's columns on the single 32x32 multiplier, then per
// output row a start state, the quotient steps and the finish registers of the shared divider.
// A zero divisor ends a transform right after the divisor row. The input is ready only in idle.
// Reset loads the identity matrix at once. A waiting result lets the next request in;
// a transform that finishes meanwhile holds until the output register frees.
module homogeneous_point_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [3:0] elem_index, [35:4] elem_value, [67:36] coord_x, [99:68] coord_y,
    // [131:100] coord_z, [135:132] zero pad
    input  logic [hpt_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [1:0] op
    input  logic [hpt_pkg::OP_W-1:0]          i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z
    output logic [hpt_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // [0] zero_divisor
    output logic                              o_m_tuser
);

    localparam int DW = hpt_pkg::DATA_W;
    localparam logic [DW-1:0] W_ONE = DW'(1) << FRAC_BITS;

    // request fields
    hpt_pkg::t_op              in_op;
    logic [hpt_pkg::IDX_W-1:0] in_index;
    logic [DW-1:0]             in_value;
    logic [DW-1:0]             in_x;
    logic [DW-1:0]             in_y;
    logic [DW-1:0]             in_z;

    assign in_op    = hpt_pkg::t_op'(i_s_tuser);
    assign in_index = i_s_tdata[3:0];
    assign in_value = i_s_tdata[35:4];
    assign in_x     = i_s_tdata[67:36];
    assign in_y     = i_s_tdata[99:68];
    assign in_z     = i_s_tdata[131:100];

    // matrix store, identity after reset
    logic [DW-1:0]             r_mat [16];
    logic                      mat_we;
    logic [hpt_pkg::IDX_W-1:0] mat_waddr;
    logic [DW-1:0]             mat_wdata;
    logic [hpt_pkg::IDX_W-1:0] mat_raddr;
    logic [DW-1:0]             mat_rd;

    hpt_pkg::t_state r_state, n_state;
    logic [hpt_pkg::ROW_W-1:0] r_row, n_row;
    logic [hpt_pkg::COL_W-1:0] r_col, n_col;
    logic                      r_out_valid, n_out_valid;

    logic signed [hpt_pkg::SUM_W-1:0]  r_acc, n_acc;
    logic signed [hpt_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [DW-1:0]                     r_x, n_x;
    logic [DW-1:0]                     r_y, n_y;
    logic [DW-1:0]                     r_z, n_z;
    logic signed [hpt_pkg::SUM_W-1:0]  r_num, n_num;
    logic signed [hpt_pkg::SUM_W-1:0]  r_den, n_den;
    logic [DW-1:0]                     r_qx, n_qx;
    logic [DW-1:0]                     r_qy, n_qy;
    logic [DW-1:0]                     r_qz, n_qz;
    logic                              r_zero, n_zero;
    logic [hpt_pkg::OUT_DATA_W-1:0]    r_out_data, n_out_data;
    logic                              r_out_zero, n_out_zero;

    logic [hpt_pkg::ROW_W-1:0]         vsel;
    logic [DW-1:0]                     v_sel;
    logic signed [hpt_pkg::PROD_W-1:0] mul;
    logic signed [hpt_pkg::SUM_W-1:0]  acc_sum;
    logic [DW:0]                       col_sum;
    logic [DW-1:0]                     col_sat;
    logic                              div_start;
    logic                              div_done;
    logic [hpt_pkg::QUOT_W-1:0]        div_quot;

    // one read port: last column during translate, the current element otherwise
    assign mat_raddr = (r_state == hpt_pkg::S_TRANS) ? {r_row, 2'b11} : {r_row, r_col[1:0]};
    assign mat_rd    = r_mat[mat_raddr];

    assign vsel = (r_state == hpt_pkg::S_TRANS) ? r_row : r_col[1:0];
    always_comb begin
        case (vsel)
            2'd0:    v_sel = r_x;
            2'd1:    v_sel = r_y;
            2'd2:    v_sel = r_z;
            default: v_sel = W_ONE;   // homogeneous w of the point
        endcase
    end

    assign mul     = $signed(mat_rd) * $signed(v_sel);
    assign acc_sum = r_acc + {{(hpt_pkg::SUM_W - hpt_pkg::PROD_W){r_prod[hpt_pkg::PROD_W-1]}},
                              r_prod};

    // saturating add for translate
    assign col_sum = {mat_rd[DW-1], mat_rd} + {v_sel[DW-1], v_sel};
    assign col_sat = (col_sum[DW] != col_sum[DW-1])
                   ? (col_sum[DW] ? hpt_pkg::SAT_MIN : hpt_pkg::SAT_MAX)
                   : col_sum[DW-1:0];

    hpt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hpt_pkg::S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_prod     <= n_prod;
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_num      <= n_num;
        r_den      <= n_den;
        r_qx       <= n_qx;
        r_qy       <= n_qy;
        r_qz       <= n_qz;
        r_zero     <= n_zero;
        r_out_data <= n_out_data;
        r_out_zero <= n_out_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= ((i % 5) == 0) ? W_ONE : '0;
            end
        end else if (mat_we) begin
            r_mat[mat_waddr] <= mat_wdata;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_num       = r_num;
        n_den       = r_den;
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_qz        = r_qz;
        n_zero      = r_zero;
        n_out_valid = r_out_valid & ~i_m_tready;   // drop once taken
        n_out_data  = r_out_data;
        n_out_zero  = r_out_zero;
        mat_we      = 1'b0;
        mat_waddr   = '0;
        mat_wdata   = '0;
        div_start   = 1'b0;
        o_s_tready  = (r_state == hpt_pkg::S_IDLE);

        case (r_state)
            hpt_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    case (in_op)
                        hpt_pkg::OP_WRITE: begin
                            mat_we    = 1'b1;
                            mat_waddr = in_index;
                            mat_wdata = in_value;
                        end
                        hpt_pkg::OP_TRANSLATE: begin
                            n_x     = in_x;
                            n_y     = in_y;
                            n_z     = in_z;
                            n_row   = '0;
                            n_state = hpt_pkg::S_TRANS;
                        end
                        hpt_pkg::OP_TRANSFORM: begin
                            n_x     = in_x;
                            n_y     = in_y;
                            n_z     = in_z;
                            n_row   = '1;   // divisor row first
                            n_col   = '0;
                            n_acc   = '0;
                            n_state = hpt_pkg::S_MAC;
                        end
                        default: begin
                            // unused opcode: drop the request
                        end
                    endcase
                end
            end

            hpt_pkg::S_TRANS: begin
                mat_we    = 1'b1;
                mat_waddr = {r_row, 2'b11};
                mat_wdata = col_sat;
                if (r_row == 2'd2) begin
                    n_state = hpt_pkg::S_IDLE;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end

            hpt_pkg::S_MAC: begin
                // product of this column, accumulate the one before
                if (r_col != 3'd4) begin
                    n_prod = mul;
                end
                if (r_col != 3'd0) begin
                    n_acc = acc_sum;
                end
                n_col = r_col + 1'b1;
                if (r_col == 3'd4) begin
                    n_col = '0;
                    if (r_row == 2'd3) begin
                        n_den = acc_sum;
                        if (acc_sum == '0) begin
                            n_zero  = 1'b1;
                            n_state = hpt_pkg::S_OUT;
                        end else begin
                            n_zero = 1'b0;
                            n_row  = '0;
                            n_acc  = '0;
                        end
                    end else begin
                        n_num   = acc_sum;
                        n_state = hpt_pkg::S_START;
                    end
                end
            end

            hpt_pkg::S_START: begin
                div_start = 1'b1;
                n_state   = hpt_pkg::S_DIV;
            end

            hpt_pkg::S_DIV: begin
                if (div_done) begin
                    case (r_row)
                        2'd0:    n_qx = div_quot;
                        2'd1:    n_qy = div_quot;
                        default: n_qz = div_quot;
                    endcase
                    if (r_row == 2'd2) begin
                        n_state = hpt_pkg::S_OUT;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_col   = '0;
                        n_acc   = '0;
                        n_state = hpt_pkg::S_MAC;
                    end
                end
            end

            hpt_pkg::S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_zero ? '0 : {r_qz, r_qy, r_qx};
                    n_out_zero  = r_zero;
                    n_state     = hpt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = hpt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_zero;

endmodule
